/* sv/chdec_pkg.sv */
// ----------------------------------------------------------------------------
// chdec_pkg
// Shared types, codes and helpers of the chunked body decoder.
// ----------------------------------------------------------------------------
package chdec_pkg;

    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_SIZE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIZE_CR = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DATA    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_TRAIL   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE    = 3'd4;

    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] status;
        logic       final_res;
    } res_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.value = 4'(b - 8'h37);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

/* sv/chdec_core.sv */
// ----------------------------------------------------------------------------
// chdec_core
// Decoder state and the per-byte step: size line parsing, payload pass-through,
// trailer skip and the closing status.
// ----------------------------------------------------------------------------
module chdec_core #(
    parameter int SIZE_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_take,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output logic               res_push,
    output chdec_pkg::res_t    res_data
);

    logic [chdec_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [SIZE_WIDTH-1:0]         accum_reg, accum_next;
    logic                          bad_reg, bad_next;
    logic                          digit_reg, digit_next;
    logic [SIZE_WIDTH-1:0]         left_reg, left_next;
    logic                          sent_reg, sent_next;

    chdec_pkg::hex_t        hex;
    logic                   take_bad_in;
    logic                   take_bad;
    logic                   take_digit;
    logic [SIZE_WIDTH-1:0]  take_accum;
    logic [SIZE_WIDTH-1:0]  left_dec;
    logic                   size_line_done;
    logic                   fin;
    logic                   valid;
    logic [2:0]             status;

    assign hex      = chdec_pkg::hex_digit(in_byte);
    assign left_dec = left_reg - SIZE_WIDTH'(1);

    // A CR not followed by LF poisons the line before the byte is taken
    assign take_bad_in = (phase_reg == chdec_pkg::PH_SIZE_CR) ? 1'b1 : bad_reg;

    always_comb begin
        take_bad   = take_bad_in;
        take_digit = digit_reg;
        take_accum = accum_reg;
        if (!hex.is_hex) begin
            take_bad = 1'b1;
        end else begin
            take_digit = 1'b1;
            if (!take_bad_in) begin
                if (accum_reg[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                    take_bad = 1'b1;
                end else begin
                    take_accum = {accum_reg[SIZE_WIDTH-5:0], hex.value};
                end
            end
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        bad_next       = bad_reg;
        digit_next     = digit_reg;
        left_next      = left_reg;
        sent_next      = sent_reg;
        size_line_done = 1'b0;
        fin            = 1'b0;
        valid          = 1'b0;
        status         = chdec_pkg::ST_RUN;

        unique case (phase_reg)
            chdec_pkg::PH_SIZE: begin
                if (in_byte == chdec_pkg::CHAR_CR) begin
                    phase_next = chdec_pkg::PH_SIZE_CR;
                end else begin
                    accum_next = take_accum;
                    bad_next   = take_bad;
                    digit_next = take_digit;
                end
            end
            chdec_pkg::PH_SIZE_CR: begin
                if (in_byte == chdec_pkg::CHAR_LF) begin
                    size_line_done = 1'b1;
                end else if (in_byte == chdec_pkg::CHAR_CR) begin
                    bad_next = 1'b1;
                end else begin
                    accum_next = take_accum;
                    bad_next   = take_bad;
                    digit_next = take_digit;
                    phase_next = chdec_pkg::PH_SIZE;
                end
            end
            chdec_pkg::PH_DATA: begin
                valid     = 1'b1;
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = chdec_pkg::PH_TRAIL;
                    left_next  = SIZE_WIDTH'(2);
                end
            end
            chdec_pkg::PH_TRAIL: begin
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = chdec_pkg::PH_SIZE;
                end
            end
            default: begin
            end
        endcase

        if (size_line_done) begin
            if (bad_reg || !digit_reg) begin
                fin        = 1'b1;
                status     = chdec_pkg::ST_INVALID;
                phase_next = chdec_pkg::PH_DONE;
            end else if (accum_reg == '0) begin
                fin        = 1'b1;
                status     = chdec_pkg::ST_OK;
                phase_next = chdec_pkg::PH_DONE;
            end else begin
                left_next  = accum_reg;
                phase_next = chdec_pkg::PH_DATA;
            end
            accum_next = '0;
            bad_next   = 1'b0;
            digit_next = 1'b0;
        end

        if (in_last && !fin && !sent_reg) begin
            fin = 1'b1;
            unique case (phase_next)
                chdec_pkg::PH_SIZE:
                    status = (digit_next || bad_next) ? chdec_pkg::ST_MISSING
                                                      : chdec_pkg::ST_OK;
                chdec_pkg::PH_SIZE_CR: status = chdec_pkg::ST_MISSING;
                chdec_pkg::PH_DATA:    status = chdec_pkg::ST_TRUNC;
                default:               status = chdec_pkg::ST_OK;
            endcase
        end

        if (fin) begin
            sent_next = 1'b1;
        end

        // End of body: drop all state back to the start of a size line
        if (in_last) begin
            phase_next = chdec_pkg::PH_SIZE;
            accum_next = '0;
            bad_next   = 1'b0;
            digit_next = 1'b0;
            left_next  = '0;
            sent_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= chdec_pkg::PH_SIZE;
            accum_reg <= '0;
            bad_reg   <= 1'b0;
            digit_reg <= 1'b0;
            left_reg  <= '0;
            sent_reg  <= 1'b0;
        end else if (in_take) begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            bad_reg   <= bad_next;
            digit_reg <= digit_next;
            left_reg  <= left_next;
            sent_reg  <= sent_next;
        end
    end

    assign res_push            = in_take && (valid || fin);
    assign res_data.out_byte   = valid ? in_byte : 8'd0;
    assign res_data.byte_valid = valid;
    assign res_data.status     = status;
    assign res_data.final_res  = fin;

endmodule

/* sv/chdec_out_buf.sv */
// ----------------------------------------------------------------------------
// chdec_out_buf
// Two-entry result queue: decouples the decoder from a stalling receiver so
// that a byte can be taken every cycle while an entry is free.
// ----------------------------------------------------------------------------
module chdec_out_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  chdec_pkg::res_t push_data,
    output logic            has_room,
    output logic            out_valid,
    input  logic            out_ready,
    output chdec_pkg::res_t out_data
);

    chdec_pkg::res_t mem [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            pop;

    assign has_room  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/http_chunked_body_decoder.sv */
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP/1.1 chunked body into its payload bytes and a closing status.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one raw body byte per item, s_tlast marking the last
//   byte of a body. Each payload byte gives one m_ item with m_tuser high; the
//   item that closes a body has m_tlast high and a non-zero status (ok,
//   missing size line, invalid size, truncated). A payload byte and the close
//   may share one item. Size lines, trailer bytes and bytes after the close
//   give no item. Payload bytes already sent before an error are to be
//   discarded by the receiver.
//   Output: a result is registered in the result queue before it shows on m_.
//   Throughput: one byte per cycle unless the queue is full; a byte's state
//   update is a single registered step (size digit shift or one count decrement).
//   Reset: state returns to the start of a size line and the result queue
//   empties. The decoder state does the same after every byte flagged s_tlast.
//   Stall: a two-entry result queue holds results while m_tready is low;
//   s_tready drops only once both entries are taken.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
    parameter int SIZE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_body
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, rest zero
    output logic        m_tuser,   // byte_valid
    output logic        m_tlast    // final_res
);

    logic            take;
    logic            res_push;
    chdec_pkg::res_t res_data;
    chdec_pkg::res_t out_data;

    assign take = s_tvalid && s_tready;

    chdec_core #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_take  (take),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .res_push (res_push),
        .res_data (res_data)
    );

    chdec_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .has_room  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {5'd0, out_data.status, out_data.out_byte};
    assign m_tuser = out_data.byte_valid;
    assign m_tlast = out_data.final_res;

    // Closing items carry a real status, all others carry running status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[10:8] != chdec_pkg::ST_RUN)
        else $error("closing item without status");

    // An item that does not close the body must carry a payload byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser && m_tdata[10:8] == chdec_pkg::ST_RUN)
        else $error("empty non-closing item");

    // A result pushed into an empty queue shows on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_push && !m_tvalid |=> m_tvalid)
        else $error("pushed result lost");

    // Results are only produced for accepted bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> take)
        else $error("result without accepted byte");

endmodule
